// ===== sv/spu_pkg.sv =====
// Shared types and constants for the sorted position table.
// No dependencies; imported by every module of the block.
package spu_pkg;

  localparam int POS_W = 32;
  localparam int TYPE_W = 8;
  localparam int ACT_W = 2;
  localparam int RIDX_W = 6;
  localparam int SLOT_W = 6;
  localparam int CNT_W = 7;

  // Request action codes; the fourth code means nothing and falls to default arms
  typedef enum logic [ACT_W-1:0] {
    ACT_UPSERT = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_t;

  // Per-cycle commands broadcast to every cell
  typedef struct packed {
    logic cmp_en;   // register compare flags against the latched request
    logic upd_en;   // overwrite type in the matching cell
    logic ins_en;   // insert at the sorted slot and shift the tail up
    logic clr_en;   // drop every entry
  } cell_ctl_t;

  // Registered compare flags of one cell
  typedef struct packed {
    logic eq;       // valid entry with position equal to the key
    logic lt;       // valid entry with position below the key
    logic rsel;     // valid entry at the requested read index
  } cell_flags_t;

endpackage

// ===== sv/spu_cell.sv =====
// One slot of the sorted table: holds an entry and its valid bit.
// Depends on spu_pkg; takes shifted data from the previous cell.
module spu_cell #(
  parameter int INDEX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  spu_pkg::cell_ctl_t          ctl,
  input  logic [spu_pkg::POS_W-1:0]   key,
  input  logic [spu_pkg::TYPE_W-1:0]  btype,
  input  logic [spu_pkg::RIDX_W-1:0]  read_index,
  input  logic                        prev_lt,
  input  logic                        prev_valid,
  input  logic [spu_pkg::POS_W-1:0]   prev_pos,
  input  logic [spu_pkg::TYPE_W-1:0]  prev_type,
  output logic                        valid,
  output logic [spu_pkg::POS_W-1:0]   pos,
  output logic [spu_pkg::TYPE_W-1:0]  etype,
  output spu_pkg::cell_flags_t        flags
);
  import spu_pkg::*;

  logic                valid_r, valid_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [TYPE_W-1:0]   type_r, type_nxt;
  cell_flags_t         flags_r, flags_nxt;

  // Compare the stored entry against the request
  always_comb begin
    flags_nxt = flags_r;
    if (ctl.cmp_en) begin
      flags_nxt.eq   = valid_r && (pos_r == key);
      flags_nxt.lt   = valid_r && (pos_r < key);
      flags_nxt.rsel = valid_r && (int'(read_index) == INDEX);
    end
  end

  // Overwrite, insert, shift or drop the entry
  always_comb begin
    valid_nxt = valid_r;
    pos_nxt   = pos_r;
    type_nxt  = type_r;
    if (ctl.clr_en) begin
      valid_nxt = 1'b0;
    end else if (ctl.upd_en && flags_r.eq) begin
      type_nxt = btype;
    end else if (ctl.ins_en && !flags_r.lt) begin
      if (prev_lt) begin
        valid_nxt = 1'b1;
        pos_nxt   = key;
        type_nxt  = btype;
      end else begin
        valid_nxt = prev_valid;
        pos_nxt   = prev_pos;
        type_nxt  = prev_type;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      flags_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    type_r <= type_nxt;
  end

  assign valid = valid_r;
  assign pos   = pos_r;
  assign etype = type_r;
  assign flags = flags_r;

endmodule

// ===== sv/spu_collect.sv =====
// Gathers cell flags into match slot, insert slot and read data.
// Depends on spu_pkg; fed by the row of spu_cell instances.
module spu_collect #(
  parameter int TABLE_CAPACITY = 64
) (
  input  spu_pkg::cell_flags_t        flags [TABLE_CAPACITY],
  input  logic [spu_pkg::POS_W-1:0]   pos   [TABLE_CAPACITY],
  input  logic [spu_pkg::TYPE_W-1:0]  etype [TABLE_CAPACITY],
  output logic                        hit_any,
  output logic [$clog2(TABLE_CAPACITY)-1:0] hit_idx,
  output logic [$clog2(TABLE_CAPACITY)-1:0] ins_idx,
  output logic                        rd_any,
  output logic [spu_pkg::POS_W-1:0]   rd_pos,
  output logic [spu_pkg::TYPE_W-1:0]  rd_type
);
  import spu_pkg::*;

  localparam int IW = $clog2(TABLE_CAPACITY);

  // Encode the one-hot match, the sorted-slot boundary and the read select
  always_comb begin
    logic boundary;
    hit_any = 1'b0;
    hit_idx = '0;
    ins_idx = '0;
    rd_any  = 1'b0;
    rd_pos  = '0;
    rd_type = '0;
    for (int i = 0; i < TABLE_CAPACITY; i++) begin
      boundary = !flags[i].lt && ((i == 0) || flags[(i == 0) ? 0 : i - 1].lt);
      if (flags[i].eq) begin
        hit_any = 1'b1;
        hit_idx = hit_idx | IW'(i);
      end
      if (boundary) begin
        ins_idx = ins_idx | IW'(i);
      end
      if (flags[i].rsel) begin
        rd_any  = 1'b1;
        rd_pos  = rd_pos | pos[i];
        rd_type = rd_type | etype[i];
      end
    end
  end

endmodule

// ===== sv/sorted_position_upsert.sv =====
// Sorted (position, type) table built as a row of shifting cells.
// A request accepted in ST_IDLE passes the compare state (ST_CMP) and the
// shift/apply state (ST_APPLY); out_strobe is registered from ST_APPLY. busy
// is high in both states, so a new request is taken only once the last is done.
// Reset empties the table; results cannot be stalled by the receiver.
module sorted_position_upsert #(
  parameter int TABLE_CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [spu_pkg::ACT_W-1:0]   in_action,
  input  logic [spu_pkg::POS_W-1:0]   in_position,
  input  logic [spu_pkg::TYPE_W-1:0]  in_base_type,
  input  logic [spu_pkg::RIDX_W-1:0]  in_read_index,
  output logic                        out_strobe,
  output logic [spu_pkg::SLOT_W-1:0]  out_slot_index,
  output logic                        out_replaced,
  output logic                        out_full_drop,
  output logic [spu_pkg::CNT_W-1:0]   out_entry_count,
  output logic [spu_pkg::POS_W-1:0]   out_read_position,
  output logic [spu_pkg::TYPE_W-1:0]  out_read_type,
  output logic                        out_read_valid
);
  import spu_pkg::*;

  localparam int IW = $clog2(TABLE_CAPACITY);
  localparam int CW = $clog2(TABLE_CAPACITY + 1);

  state_t              state_r, state_nxt;
  logic [ACT_W-1:0]    act_r;
  logic [POS_W-1:0]    key_r;
  logic [TYPE_W-1:0]   btype_r;
  logic [RIDX_W-1:0]   ridx_r;
  logic [CW-1:0]       count_r, count_nxt;
  cell_ctl_t           ctl;
  logic                accept;
  logic                full;

  logic                cell_valid [TABLE_CAPACITY];
  logic [POS_W-1:0]    cell_pos   [TABLE_CAPACITY];
  logic [TYPE_W-1:0]   cell_type  [TABLE_CAPACITY];
  cell_flags_t         cell_flags [TABLE_CAPACITY];

  logic                hit_any, rd_any;
  logic [IW-1:0]       hit_idx, ins_idx;
  logic [POS_W-1:0]    rd_pos;
  logic [TYPE_W-1:0]   rd_type;

  logic                strobe_r;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                repl_r, repl_nxt;
  logic                drop_r, drop_nxt;
  logic [CNT_W-1:0]    cnt_out_r;
  logic [POS_W-1:0]    rpos_r, rpos_nxt;
  logic [TYPE_W-1:0]   rtype_r, rtype_nxt;
  logic                rvalid_r, rvalid_nxt;

  assign accept = start && !busy;
  assign full   = (count_r == CW'(TABLE_CAPACITY));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State outputs: busy and cell commands
  always_comb begin
    busy = 1'b0;
    ctl  = '0;
    unique case (state_r)
      ST_IDLE: ;
      ST_CMP: begin
        busy       = 1'b1;
        ctl.cmp_en = 1'b1;
      end
      ST_APPLY: begin
        busy       = 1'b1;
        ctl.upd_en = (act_r == ACT_UPSERT) && hit_any;
        ctl.ins_en = (act_r == ACT_UPSERT) && !hit_any && !full;
        ctl.clr_en = (act_r == ACT_CLEAR);
      end
      default: ;
    endcase
  end

  // Row of cells; each takes the previous cell's entry on a shift
  for (genvar g = 0; g < TABLE_CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      spu_cell #(.INDEX(g)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .key        (key_r),
        .btype      (btype_r),
        .read_index (ridx_r),
        .prev_lt    (1'b1),
        .prev_valid (1'b0),
        .prev_pos   (key_r),
        .prev_type  (btype_r),
        .valid      (cell_valid[g]),
        .pos        (cell_pos[g]),
        .etype      (cell_type[g]),
        .flags      (cell_flags[g])
      );
    end else begin : g_body
      spu_cell #(.INDEX(g)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .key        (key_r),
        .btype      (btype_r),
        .read_index (ridx_r),
        .prev_lt    (cell_flags[g-1].lt),
        .prev_valid (cell_valid[g-1]),
        .prev_pos   (cell_pos[g-1]),
        .prev_type  (cell_type[g-1]),
        .valid      (cell_valid[g]),
        .pos        (cell_pos[g]),
        .etype      (cell_type[g]),
        .flags      (cell_flags[g])
      );
    end
  end

  spu_collect #(.TABLE_CAPACITY(TABLE_CAPACITY)) u_collect (
    .flags   (cell_flags),
    .pos     (cell_pos),
    .etype   (cell_type),
    .hit_any (hit_any),
    .hit_idx (hit_idx),
    .ins_idx (ins_idx),
    .rd_any  (rd_any),
    .rd_pos  (rd_pos),
    .rd_type (rd_type)
  );

  // Build the result and the new entry count
  always_comb begin
    count_nxt  = count_r;
    slot_nxt   = '0;
    repl_nxt   = 1'b0;
    drop_nxt   = 1'b0;
    rpos_nxt   = '0;
    rtype_nxt  = '0;
    rvalid_nxt = 1'b0;
    unique case (act_r)
      ACT_UPSERT: begin
        if (hit_any) begin
          slot_nxt = SLOT_W'(hit_idx);
          repl_nxt = 1'b1;
        end else if (full) begin
          drop_nxt = 1'b1;
        end else begin
          slot_nxt  = SLOT_W'(ins_idx);
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_READ: begin
        slot_nxt   = SLOT_W'(ridx_r);
        rvalid_nxt = rd_any;
        rpos_nxt   = rd_pos;
        rtype_nxt  = rd_type;
      end
      ACT_CLEAR: count_nxt = '0;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == ST_APPLY);
      if (state_r == ST_APPLY) count_r <= count_nxt;
    end
  end

  // Hold the request and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= in_action;
      key_r   <= in_position;
      btype_r <= in_base_type;
      ridx_r  <= in_read_index;
    end
    if (state_r == ST_APPLY) begin
      slot_r    <= slot_nxt;
      repl_r    <= repl_nxt;
      drop_r    <= drop_nxt;
      cnt_out_r <= CNT_W'(count_nxt);
      rpos_r    <= rpos_nxt;
      rtype_r   <= rtype_nxt;
      rvalid_r  <= rvalid_nxt;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_slot_index    = slot_r;
  assign out_replaced      = repl_r;
  assign out_full_drop     = drop_r;
  assign out_entry_count   = cnt_out_r;
  assign out_read_position = rpos_r;
  assign out_read_type     = rtype_r;
  assign out_read_valid    = rvalid_r;

endmodule
